### hw/rtl/frc_pkg.sv
// Package: word types, status and action codes, and the CRC-16 byte update.
`timescale 1ns / 1ps
package frc_pkg;

  localparam int BUFFER_BYTES_DEF = 64;
  localparam int HEADER_LEN       = 6;
  localparam int BODY_W           = 9;
  localparam logic [15:0] CRC_POLY = 16'hA001;
  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [31:0] MARKER_RESET = 32'h7FFF_FFFF;

  typedef enum logic [1:0] {
    ACT_RX      = 2'd0,
    ACT_READ    = 2'd1,
    ACT_RELEASE = 2'd2
  } action_t;

  typedef enum logic [3:0] {
    ST_PROGRESS  = 4'd0,
    ST_MISMATCH  = 4'd1,
    ST_FRAME_ERR = 4'd2,
    ST_OVERRUN   = 4'd3,
    ST_ACCEPTED  = 4'd4,
    ST_CRC_BAD   = 4'd5,
    ST_DROP_BUSY = 4'd6,
    ST_TOO_LONG  = 4'd7,
    ST_READ      = 4'd8,
    ST_RELEASED  = 4'd9
  } status_t;

  typedef struct packed {
    logic [1:0] action;
    logic [7:0] rx_byte;
    logic       frame_error;
    logic       overrun;
    logic [5:0] read_index;
  } in_t;

  typedef struct packed {
    status_t    status;
    logic [7:0] read_data;
    logic       frame_held;
    logic [6:0] held_length;
  } out_t;

  typedef struct packed {
    status_t    status;
    logic       frame_held;
    logic [6:0] held_length;
    logic       rd_en;
  } res_t;

  function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

### hw/rtl/frc_store.sv
// Frame store: two-half byte memory with one write port and a registered read.
`timescale 1ns / 1ps
module frc_store #(
  parameter int ADDR_W = 7
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [7:0]        wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [7:0]        rd_data
);

  logic [7:0] mem [2**ADDR_W];
  logic [7:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

### hw/rtl/frc_ctrl.sv
// Receive control: marker search, byte counter, CRC, half swap and held state.
`timescale 1ns / 1ps
module frc_ctrl import frc_pkg::*; #(
  parameter int BUFFER_BYTES = BUFFER_BYTES_DEF,
  parameter int AW           = $clog2(BUFFER_BYTES)
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          accept,
  input  in_t           in_word,
  input  logic          cfg_wr_en,
  input  logic [31:0]   cfg_wr_data,
  output logic          wr_en,
  output logic [AW:0]   wr_addr,
  output logic [7:0]    wr_data,
  output logic [AW:0]   rd_addr,
  output res_t          res
);

  localparam int CNT_W = $clog2(BUFFER_BYTES + 2);
  localparam int HC_W  = $clog2(BUFFER_BYTES + 1);

  logic [31:0]      marker_r;
  logic             half_r, half_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [7:0]       plen_r, plen_nxt;
  logic [15:0]      crc_r, crc_nxt;
  logic [7:0]       fcb_r, fcb_nxt;
  logic             held_r, held_nxt;
  logic [HC_W-1:0]  hcnt_r, hcnt_nxt;

  logic [BODY_W-1:0] pos, body;
  logic [7:0]        want;
  status_t           status;
  logic              rd_ok;
  logic              take;

  always_comb begin
    unique case (cnt_r[1:0])
      2'd0:    want = marker_r[31:24];
      2'd1:    want = marker_r[23:16];
      2'd2:    want = marker_r[15:8];
      default: want = marker_r[7:0];
    endcase
  end

  always_comb begin
    pos      = BODY_W'(cnt_r);
    body     = BODY_W'(HEADER_LEN) + BODY_W'(plen_r);
    half_nxt = half_r;
    cnt_nxt  = cnt_r;
    plen_nxt = plen_r;
    crc_nxt  = crc_r;
    fcb_nxt  = fcb_r;
    held_nxt = held_r;
    hcnt_nxt = hcnt_r;
    status   = ST_PROGRESS;
    take     = 1'b0;
    rd_ok    = 1'b0;
    if (accept) begin
      unique case (in_word.action)
        ACT_RX: begin
          if (in_word.frame_error) begin
            cnt_nxt = '0;
            status  = ST_FRAME_ERR;
          end else if (in_word.overrun) begin
            cnt_nxt = '0;
            status  = ST_OVERRUN;
          end else if (pos < BODY_W'(4)) begin
            if (in_word.rx_byte != want) begin
              cnt_nxt = '0;
              status  = ST_MISMATCH;
            end else begin
              take = 1'b1;
            end
          end else if (pos == BODY_W'(4)) begin
            take = 1'b1;
          end else if (pos == BODY_W'(5)) begin
            plen_nxt = in_word.rx_byte;
            if (BODY_W'(HEADER_LEN) + BODY_W'(in_word.rx_byte) > BODY_W'(BUFFER_BYTES)) begin
              cnt_nxt = '0;
              status  = ST_TOO_LONG;
            end else begin
              take = 1'b1;
            end
          end else if (pos < body) begin
            take = 1'b1;
          end else if (pos == body) begin
            fcb_nxt = in_word.rx_byte;
            cnt_nxt = cnt_r + CNT_W'(1);
          end else begin
            cnt_nxt = '0;
            if (fcb_r != crc_r[7:0] || in_word.rx_byte != crc_r[15:8]) begin
              status = ST_CRC_BAD;
            end else if (held_r) begin
              status = ST_DROP_BUSY;
            end else begin
              half_nxt = ~half_r;
              held_nxt = 1'b1;
              hcnt_nxt = HC_W'(body);
              status   = ST_ACCEPTED;
            end
          end
          if (take) begin
            crc_nxt = crc16_byte((pos == '0) ? CRC_INIT : crc_r, in_word.rx_byte);
            cnt_nxt = cnt_r + CNT_W'(1);
          end
        end
        ACT_READ: begin
          status = ST_READ;
          rd_ok  = held_r && (BODY_W'(in_word.read_index) < BODY_W'(hcnt_r));
        end
        ACT_RELEASE: begin
          held_nxt = 1'b0;
          hcnt_nxt = '0;
          status   = ST_RELEASED;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      marker_r <= MARKER_RESET;
      half_r   <= 1'b0;
      cnt_r    <= '0;
      plen_r   <= '0;
      crc_r    <= CRC_INIT;
      fcb_r    <= '0;
      held_r   <= 1'b0;
      hcnt_r   <= '0;
    end else begin
      if (cfg_wr_en) begin
        marker_r <= cfg_wr_data;
      end
      half_r <= half_nxt;
      cnt_r  <= cnt_nxt;
      plen_r <= plen_nxt;
      crc_r  <= crc_nxt;
      fcb_r  <= fcb_nxt;
      held_r <= held_nxt;
      hcnt_r <= hcnt_nxt;
    end
  end

  assign wr_en   = take;
  assign wr_addr = {half_r, AW'(cnt_r)};
  assign wr_data = in_word.rx_byte;
  assign rd_addr = {~half_r, AW'(in_word.read_index)};

  assign res.status      = status;
  assign res.frame_held  = held_nxt;
  assign res.held_length = 7'(hcnt_nxt);
  assign res.rd_en       = rd_ok;

endmodule

### hw/rtl/framed_byte_receiver_crc16.sv
// Top level: framed byte receiver with CRC-16 check and two-half frame store.
// A result word is registered with its store read, then in the output register, which holds it while out_stall is high.
// Throughput: one word per cycle while the output side is not stalled; the store takes one write and one read a cycle.
// A held byte is read through the store's registered port, which sets the latency.
// Reset is synchronous, active low; counters, CRC and held state clear at once.
// Store contents are not cleared; a held frame is always written before it is read.
`timescale 1ns / 1ps
module framed_byte_receiver_crc16 import frc_pkg::*; #(
  parameter int BUFFER_BYTES = BUFFER_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  in_t         in_word,
  output logic        out_valid,
  input  logic        out_stall,
  output out_t        out_word,
  input  logic        cfg_wr_en,
  input  logic [31:0] cfg_wr_data
);

  localparam int AW = $clog2(BUFFER_BYTES);

  logic        accept;
  logic        a_move;
  logic        a_valid_r;
  res_t        a_res_r;
  logic        b_valid_r;
  out_t        out_word_r;
  res_t        res;
  logic        wr_en;
  logic [AW:0] wr_addr;
  logic [7:0]  wr_data;
  logic [AW:0] rd_addr;
  logic [7:0]  rd_data;

  assign a_move   = a_valid_r && (!b_valid_r || !out_stall);
  assign in_stall = a_valid_r && !a_move;
  assign accept   = in_valid && !in_stall;

  frc_ctrl #(
    .BUFFER_BYTES(BUFFER_BYTES),
    .AW          (AW)
  ) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .accept     (accept),
    .in_word    (in_word),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .wr_en      (wr_en),
    .wr_addr    (wr_addr),
    .wr_data    (wr_data),
    .rd_addr    (rd_addr),
    .res        (res)
  );

  frc_store #(
    .ADDR_W(AW + 1)
  ) u_store (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(wr_addr),
    .wr_data(wr_data),
    .rd_en  (accept),
    .rd_addr(rd_addr),
    .rd_data(rd_data)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
      b_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        a_valid_r <= 1'b1;
      end else if (a_move) begin
        a_valid_r <= 1'b0;
      end
      if (!b_valid_r || !out_stall) begin
        b_valid_r <= a_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      a_res_r <= res;
    end
    if (!b_valid_r || !out_stall) begin
      out_word_r.status      <= a_res_r.status;
      out_word_r.read_data   <= a_res_r.rd_en ? rd_data : 8'h00;
      out_word_r.frame_held  <= a_res_r.frame_held;
      out_word_r.held_length <= a_res_r.held_length;
    end
  end

  assign out_valid = b_valid_r;
  assign out_word  = out_word_r;

endmodule

### hw/rtl/frc_checker.sv
// Port checker for the frame receiver, bound to the top level.
`timescale 1ns / 1ps
module frc_checker import frc_pkg::*; (
  input logic        clk,
  input logic        rst_n,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input out_t        out_word
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_word))
    else $error("result word changed while stalled");

  a_data_only_on_read: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_word.read_data != 8'h00 |-> out_word.status == ST_READ &&
    out_word.frame_held)
    else $error("read data outside a read of a held frame");

  a_release_clears: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_word.status == ST_RELEASED |->
    !out_word.frame_held && out_word.held_length == 7'd0)
    else $error("release left a frame held");

  a_accept_holds: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_word.status == ST_ACCEPTED || out_word.status == ST_DROP_BUSY) |->
    out_word.frame_held)
    else $error("accepted or busy result without a held frame");

  a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled while the result side can move");

endmodule

bind framed_byte_receiver_crc16 frc_checker u_frc_checker (.*);

### tb/testbench.sv
// Testbench for the framed byte receiver: directed and random framed traffic checked word by word.
`timescale 1ns / 1ps
module testbench;
  import frc_pkg::*;

  localparam int STORE_HALF = 64;
  localparam int CYCLE_LIMIT = 400000;
  localparam logic [1:0] ACT_SPARE = 2'd3;

  typedef enum int {
    FLAW_NONE,
    FLAW_CHECK,
    FLAW_LINE,
    FLAW_MARKER
  } flaw_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  in_t         in_word = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  out_t        out_word;
  logic        cfg_wr_en = 1'b0;
  logic [31:0] cfg_wr_data = '0;

  framed_byte_receiver_crc16 #(.BUFFER_BYTES(STORE_HALF)) uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_word    (in_word),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_word   (out_word),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  in_t  pending_words[$];
  out_t expected_words[$];
  out_t due_word;
  int   queued_count = 0;
  int   sent_count = 0;
  int   send_gap = 0;
  int   words_seen = 0;
  int   hold_left = 0;
  int   long_left = 0;
  bit   long_done = 1'b0;
  logic long_stall = 1'b0;
  int   mismatch_count = 0;
  int   cycle_count = 0;

  logic [31:0] track_marker = MARKER_RESET;
  logic [7:0]  track_store[0:2*STORE_HALF-1];
  logic        track_half = 1'b0;
  logic [6:0]  track_pos = '0;
  logic [7:0]  track_len = '0;
  logic [15:0] track_crc = CRC_INIT;
  logic [7:0]  track_check0 = '0;
  logic        track_held = 1'b0;
  logic [6:0]  track_held_len = '0;

  initial begin
    forever #6 clk = ~clk;
  end

  function automatic logic [15:0] crc_next(input logic [15:0] c, input logic [7:0] d);
    logic [15:0] v;
    v = c;
    for (int i = 0; i < 8; i++) begin
      if (v[0] ^ d[i]) v = (v >> 1) ^ 16'hA001;
      else v = v >> 1;
    end
    return c == c ? v : v;
  endfunction

  function automatic status_t take_byte(input logic [7:0] b);
    logic [31:0] sh;
    int p;
    int body;
    int base;
    p = int'(track_pos);
    body = HEADER_LEN + int'(track_len);
    base = track_half ? STORE_HALF : 0;
    if (p < 4) begin
      sh = track_marker >> (8 * (3 - p));
      if (b != sh[7:0]) begin
        track_pos = '0;
        return ST_MISMATCH;
      end
      if (p == 0) track_crc = CRC_INIT;
      track_store[base + p] = b;
      track_crc = crc_next(track_crc, b);
      track_pos = 7'(p + 1);
      return ST_PROGRESS;
    end
    if (p == 5) begin
      track_len = b;
      if (HEADER_LEN + int'(b) > STORE_HALF) begin
        track_pos = '0;
        return ST_TOO_LONG;
      end
    end
    if (p < body || p == 5) begin
      track_store[base + p] = b;
      track_crc = crc_next(track_crc, b);
      track_pos = 7'(p + 1);
      return ST_PROGRESS;
    end
    if (p == body) begin
      track_check0 = b;
      track_pos = 7'(p + 1);
      return ST_PROGRESS;
    end
    track_pos = '0;
    if (track_check0 != track_crc[7:0] || b != track_crc[15:8]) return ST_CRC_BAD;
    if (track_held) return ST_DROP_BUSY;
    track_half = ~track_half;
    track_held = 1'b1;
    track_held_len = 7'(body);
    return ST_ACCEPTED;
  endfunction

  function automatic out_t predict_word(input in_t w);
    out_t r;
    int rd_base;
    r = '0;
    r.status = ST_PROGRESS;
    if (w.action == ACT_RX) begin
      if (w.frame_error) begin
        track_pos = '0;
        r.status = ST_FRAME_ERR;
      end else if (w.overrun) begin
        track_pos = '0;
        r.status = ST_OVERRUN;
      end else begin
        r.status = take_byte(w.rx_byte);
      end
    end else if (w.action == ACT_READ) begin
      r.status = ST_READ;
      if (track_held && {1'b0, w.read_index} < track_held_len) begin
        rd_base = track_half ? 0 : STORE_HALF;
        r.read_data = track_store[rd_base + int'(w.read_index)];
      end
    end else if (w.action == ACT_RELEASE) begin
      track_held = 1'b0;
      track_held_len = '0;
      r.status = ST_RELEASED;
    end
    r.frame_held = track_held;
    r.held_length = track_held_len;
    return r;
  endfunction

  // Driver: present queued words, draw a gap per word, record predictions on accept.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      send_gap = 0;
    end else begin
      if (in_valid && !in_stall) expected_words.push_back(predict_word(in_word));
      if (!in_valid || !in_stall) begin
        if (send_gap > 0) begin
          in_valid <= 1'b0;
          send_gap = send_gap - 1;
        end else if (pending_words.size() != 0) begin
          in_word <= pending_words.pop_front();
          in_valid <= 1'b1;
          sent_count++;
          send_gap = ((sent_count / 96) % 4 == 3) ? 0 : $urandom_range(0, 3);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Hold off the result side once for a long stretch while words keep arriving.
  always @(posedge clk) begin
    if (!rst_n) begin
      long_stall <= 1'b0;
      long_left = 0;
    end else begin
      if (!long_done && sent_count >= 400) begin
        long_done = 1'b1;
        long_left = 250;
      end
      if (long_left > 0) begin
        long_stall <= 1'b1;
        long_left = long_left - 1;
      end else begin
        long_stall <= 1'b0;
      end
    end
  end

  // Monitor: compare each accepted result word, then hold off for a drawn stretch.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      hold_left = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_words.size() == 0) begin
          $error("result word %h with nothing expected", out_word);
          mismatch_count++;
        end else begin
          due_word = expected_words.pop_front();
          if (out_word.status !== due_word.status) begin
            $error("status: expected %0d, got %0d", due_word.status, out_word.status);
            mismatch_count++;
          end
          if (out_word.read_data !== due_word.read_data) begin
            $error("read_data: expected %0h, got %0h", due_word.read_data, out_word.read_data);
            mismatch_count++;
          end
          if (out_word.frame_held !== due_word.frame_held) begin
            $error("frame_held: expected %0d, got %0d", due_word.frame_held,
                   out_word.frame_held);
            mismatch_count++;
          end
          if (out_word.held_length !== due_word.held_length) begin
            $error("held_length: expected %0d, got %0d", due_word.held_length,
                   out_word.held_length);
            mismatch_count++;
          end
        end
        words_seen++;
        if ((words_seen / 80) % 4 == 2) hold_left = 0;
        else hold_left = $urandom_range(0, 3);
      end
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left = hold_left - 1;
      end else begin
        out_stall <= long_stall;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  task automatic push_word(input logic [1:0] act, input logic [7:0] b, input logic fe,
                           input logic ovr, input logic [5:0] idx);
    in_t w;
    w.action = act;
    w.rx_byte = b;
    w.frame_error = fe;
    w.overrun = ovr;
    w.read_index = idx;
    pending_words.push_back(w);
    queued_count++;
  endtask

  task automatic push_byte(input logic [7:0] b);
    push_word(ACT_RX, b, 1'b0, 1'b0, 6'($urandom_range(0, 63)));
  endtask

  task automatic push_read(input logic [5:0] idx);
    push_word(ACT_READ, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
              1'($urandom_range(0, 1)), idx);
  endtask

  task automatic push_release();
    push_word(ACT_RELEASE, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
              1'($urandom_range(0, 1)), 6'($urandom_range(0, 63)));
  endtask

  task automatic push_frame(input logic [7:0] cmd, input logic [7:0] len, input flaw_t flaw);
    logic [7:0]  bytes_out[$];
    logic [31:0] sh;
    logic [15:0] c;
    logic        fe;
    int          at;
    c = CRC_INIT;
    for (int i = 3; i >= 0; i--) begin
      sh = track_marker >> (8 * i);
      bytes_out.push_back(sh[7:0]);
    end
    bytes_out.push_back(cmd);
    bytes_out.push_back(len);
    if (HEADER_LEN + int'(len) <= STORE_HALF) begin
      for (int i = 0; i < int'(len); i++) bytes_out.push_back(8'($urandom_range(0, 255)));
      foreach (bytes_out[i]) c = crc_next(c, bytes_out[i]);
      bytes_out.push_back(c[7:0]);
      bytes_out.push_back(c[15:8]);
    end
    at = $urandom_range(0, bytes_out.size() - 1);
    if (flaw == FLAW_CHECK) begin
      at = bytes_out.size() - 1 - $urandom_range(0, 1);
      bytes_out[at] = bytes_out[at] ^ (8'h01 << $urandom_range(0, 7));
    end else if (flaw == FLAW_MARKER) begin
      at = $urandom_range(0, 3);
      bytes_out[at] = bytes_out[at] ^ 8'($urandom_range(1, 255));
    end
    foreach (bytes_out[i]) begin
      if (flaw == FLAW_LINE && i == at) begin
        fe = 1'($urandom_range(0, 1));
        push_word(ACT_RX, bytes_out[i], fe, fe ? 1'($urandom_range(0, 1)) : 1'b1,
                  6'($urandom_range(0, 63)));
      end else begin
        push_byte(bytes_out[i]);
      end
    end
  endtask

  task automatic random_phase(input int count);
    int stop_at;
    int r;
    int len;
    int f;
    int top;
    stop_at = queued_count + count;
    while (queued_count < stop_at) begin
      r = $urandom_range(0, 99);
      if (r < 62) begin
        len = ($urandom_range(0, 15) == 0) ? $urandom_range(0, STORE_HALF - HEADER_LEN)
                                           : $urandom_range(0, 8);
        f = $urandom_range(0, 9);
        push_frame(8'($urandom_range(0, 255)), 8'(len),
                   f == 0 ? FLAW_CHECK : f == 1 ? FLAW_LINE : f == 2 ? FLAW_MARKER : FLAW_NONE);
        top = (len + 7 > 63) ? 63 : len + 7;
        repeat ($urandom_range(0, 3)) begin
          push_read(6'(($urandom_range(0, 7) == 0) ? $urandom_range(0, 63)
                                                   : $urandom_range(0, top)));
        end
        if ($urandom_range(0, 9) < 6) push_release();
      end else if (r < 70) begin
        push_frame(8'($urandom_range(0, 255)),
                   8'($urandom_range(STORE_HALF - HEADER_LEN + 1, 255)), FLAW_NONE);
      end else if (r < 80) begin
        push_read(6'($urandom_range(0, 63)));
      end else if (r < 87) begin
        push_release();
      end else begin
        push_word(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
                  1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                  6'($urandom_range(0, 63)));
      end
    end
  endtask

  task automatic drain();
    @(posedge clk);
    while (pending_words.size() != 0 || in_valid || expected_words.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_marker(input logic [31:0] v);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    track_marker = v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    push_word(ACT_SPARE, 8'hFF, 1'b1, 1'b1, 6'h3F);
    push_release();
    push_read(6'd63);
    push_byte(8'h00);
    push_word(ACT_RX, 8'h7F, 1'b1, 1'b1, 6'd0);
    push_word(ACT_RX, 8'h7F, 1'b0, 1'b1, 6'd63);
    push_frame(8'hC1, 8'd0, FLAW_NONE);
    push_read(6'd0);
    push_read(6'd5);
    push_read(6'd6);
    push_frame(8'hC0, 8'hFF, FLAW_NONE);
    push_release();
    drain();

    write_marker(32'h0000_0000);
    random_phase(250);
    drain();
    write_marker(32'hFFFF_FFFF);
    random_phase(250);
    drain();
    write_marker($urandom);
    random_phase(300);
    drain();
    write_marker(MARKER_RESET);
    random_phase(250);
    drain();

    if (mismatch_count == 0 && expected_words.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
